>>> hw/rtl/rgbkf_pkg.sv
// rgbkf_pkg: types, constants and kernel table of the rgb 3x3 kernel filter
// no dependencies
package rgbkf_pkg;

  localparam int PIX_BITS  = 8;
  localparam int CF_BITS   = 8;
  localparam int COEF_BITS = 13;
  localparam int POS_BITS  = 11;
  localparam int DIM_BITS  = 12;
  localparam int MAX_HEIGHT = 2048;
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QLVL_BITS = $clog2(QDEPTH + 1);
  localparam int PIX_MAX_I = (1 << PIX_BITS) - 1;
  localparam logic [PIX_BITS-1:0] PIX_MAX = PIX_BITS'(PIX_MAX_I);

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDENTITY = 3'd0,
    MODE_BLUR     = 3'd1,
    MODE_GAUSS    = 3'd2,
    MODE_SHARPEN  = 3'd3,
    MODE_EMBOSS   = 3'd4,
    MODE_EDGE     = 3'd5
  } mode_t;

  // signed fixed-point coefficients, CF_BITS fraction bits
  localparam logic signed [COEF_BITS-1:0] COEF_ONE     = 13'sd256;
  localparam logic signed [COEF_BITS-1:0] COEF_NINTH   = 13'sd28;
  localparam logic signed [COEF_BITS-1:0] COEF_16TH    = 13'sd16;
  localparam logic signed [COEF_BITS-1:0] COEF_8TH     = 13'sd32;
  localparam logic signed [COEF_BITS-1:0] COEF_G_MID   = 13'sd58;
  localparam logic signed [COEF_BITS-1:0] COEF_M_HALF  = -13'sd128;
  localparam logic signed [COEF_BITS-1:0] COEF_HALF    = 13'sd128;
  localparam logic signed [COEF_BITS-1:0] COEF_EIGHT   = 13'sd2048;
  localparam logic signed [COEF_BITS-1:0] COEF_M_ONE   = -13'sd256;
  localparam logic signed [COEF_BITS-1:0] COEF_ZERO    = 13'sd0;

  typedef logic [2:0][PIX_BITS-1:0] pix_t;   // [0] red, [1] green, [2] blue

  typedef struct packed {
    logic [PIX_BITS-1:0] red_in;
    logic [PIX_BITS-1:0] green_in;
    logic [PIX_BITS-1:0] blue_in;
    logic                flush;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] red_out;
    logic [PIX_BITS-1:0] green_out;
    logic [PIX_BITS-1:0] blue_out;
    logic [POS_BITS-1:0] pixel_row;
    logic [POS_BITS-1:0] pixel_col;
    logic                frame_done;
  } out_item_t;

  // one classified request: masked window plus position
  typedef struct packed {
    pix_t [8:0]          win;   // tap = row*3 + col
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                done;
  } win_item_t;

  function automatic logic signed [COEF_BITS-1:0] kernel_coef(input logic [2:0] mode,
                                                              input logic [3:0] tap);
    logic signed [COEF_BITS-1:0] c;
    c = COEF_ZERO;
    case (mode)
      MODE_BLUR: c = COEF_NINTH;
      MODE_GAUSS: begin
        if (tap == 4'd4) c = COEF_G_MID;
        else if (tap inside {4'd0, 4'd2, 4'd6, 4'd8}) c = COEF_16TH;
        else c = COEF_8TH;
      end
      MODE_SHARPEN: begin
        if (tap == 4'd4) c = COEF_EIGHT;
        else if (tap inside {4'd1, 4'd3, 4'd5, 4'd7}) c = COEF_M_HALF;
        else c = COEF_ZERO;
      end
      MODE_EMBOSS: begin
        case (tap)
          4'd0:                      c = COEF_M_ONE;
          4'd1, 4'd3:                c = COEF_M_HALF;
          4'd4, 4'd5, 4'd7:          c = COEF_HALF;
          4'd8:                      c = COEF_ONE;
          default:                   c = COEF_ZERO;
        endcase
      end
      default: c = (tap == 4'd4) ? COEF_ONE : COEF_ZERO;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/rgb_3x3_kernel_filter_core.sv
// rgb_3x3_kernel_filter_core: top level, configuration registers and block wiring
// depends on rgbkf_pkg, rgbkf_front, rgbkf_queue, rgbkf_back
//
// filters a raster-order rgb stream through a 3x3 kernel (identity, box blur, gaussian,
// sharpen, emboss or sobel squared edge magnitude), one pixel per clock while full is low.
// a pushed pixel is registered and then written to the line store; its result, if any,
// passes the window queue, the two back stages and the result register. full only
// rises when results are not popped and the window queue fills. results lag the
// input by image_width+1 requests, so image_width+1 flush requests drain a frame.
// the line store is a single MAX_WIDTH x 48 ram holding two rows per column; it has
// no clearing pass since stale entries only ever feed taps outside the image.
// writing image_width or image_height restarts the frame; write config only when idle.
module rgb_3x3_kernel_filter_core import rgbkf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_item_t    push_data,
  output logic        full,
  input  logic        pop,
  output out_item_t   pop_data,
  output logic        empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_BITS-1:0]  image_width, image_height;
  logic [2:0]           filter_mode;
  logic                 cfg_wr, restart;

  logic                 qw_valid, q_valid, q_pop;
  win_item_t            qw_data, q_head;
  logic [QLVL_BITS-1:0] q_level;

  // apb register file, zero-wait
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_BITS'(640);
      image_height <= DIM_BITS'(480);
      filter_mode  <= MODE_IDENTITY;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_BITS-1:0];
        REG_MODE:   filter_mode  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_MODE:   prdata = 32'(filter_mode);
      default:    prdata = '0;
    endcase
  end

  // front: takes requests, tracks position, line store and window
  rgbkf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (push),
    .push_data    (push_data),
    .full         (full),
    .q_level      (q_level),
    .qw_valid     (qw_valid),
    .qw_data      (qw_data)
  );

  // decoupling queue of masked windows
  rgbkf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (qw_valid),
    .wr_data (qw_data),
    .rd      (q_pop),
    .head    (q_head),
    .valid   (q_valid),
    .level   (q_level)
  );

  // back: convolution pipeline, its last stage is the result register
  rgbkf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .pop_data    (pop_data)
  );

  // queue never holds more than its depth
  a_qlevel: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLVL_BITS'(QDEPTH))
    else $error("queue level above depth");

  // front reserves room before taking a request, so a window always finds a slot
  a_qroom: assert property (@(posedge clk) disable iff (rst)
    qw_valid |-> (q_level < QLVL_BITS'(QDEPTH)))
    else $error("window written into full queue");

  // queue read only while it holds an entry
  a_qread: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_level != '0))
    else $error("queue read while empty");

endmodule

>>> hw/rtl/rgbkf_ram.sv
// rgbkf_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module rgbkf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rgbkf_front.sv
// rgbkf_front: accepts pixels, tracks frame position, keeps line store and window
// depends on rgbkf_pkg and rgbkf_ram
module rgbkf_front import rgbkf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  logic [DIM_BITS-1:0]  image_width,
  input  logic [DIM_BITS-1:0]  image_height,
  input  logic                 push,
  input  in_item_t             push_data,
  output logic                 full,
  input  logic [QLVL_BITS-1:0] q_level,
  output logic                 qw_valid,
  output win_item_t            qw_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);

  typedef pix_t [1:0] line_pair_t;   // [1] two rows up, [0] one row up

  logic [WB-1:0]       w_eff;
  logic [DIM_BITS-1:0] h_eff;
  logic [CB-1:0]       in_col;
  logic [DIM_BITS-1:0] in_row;
  logic [POS_BITS-1:0] emit_row;
  logic [CB-1:0]       emit_col;

  logic acc, started, in_frame, col_wrap, row_last, col_last, done;
  pix_t px;

  logic          s1_valid, s1_emit, s1_done;
  pix_t          s1_px;
  logic [CB-1:0] s1_c;
  logic [POS_BITS-1:0] s1_row, s1_col;
  logic [3:0]    s1_mask;   // top, bottom, left, right in bounds

  line_pair_t ram_rd, wr_word, fwd_word;
  logic       fwd;
  pix_t       top, mid;
  pix_t [2:0][2:0] win, win_next;

  always_comb begin
    if (image_width == '0) w_eff = WB'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(image_width);
    if (image_height == '0) h_eff = DIM_BITS'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = DIM_BITS'(MAX_HEIGHT);
    else h_eff = image_height;
  end

  assign full = (q_level + QLVL_BITS'(s1_valid & s1_emit)) >= QLVL_BITS'(QDEPTH);
  assign acc  = push && !full;

  always_comb begin
    started  = (in_row >= DIM_BITS'(2)) || ((in_row == DIM_BITS'(1)) && (in_col != '0));
    in_frame = in_row < h_eff;
    col_wrap = (WB'(in_col) + WB'(1)) >= w_eff;
    row_last = (DIM_BITS'(emit_row) + DIM_BITS'(1)) >= h_eff;
    col_last = (WB'(emit_col) + WB'(1)) >= w_eff;
    done     = started && row_last && col_last;
    if (in_frame && !push_data.flush)
      px = {push_data.blue_in, push_data.green_in, push_data.red_in};
    else
      px = '0;
  end

  // position counters, updated as each request is taken
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      emit_row <= '0;
      emit_col <= '0;
    end else if (acc) begin
      if (done) begin
        in_col   <= '0;
        in_row   <= '0;
        emit_row <= '0;
        emit_col <= '0;
      end else begin
        in_col <= col_wrap ? '0 : in_col + CB'(1);
        if (col_wrap) in_row <= in_row + DIM_BITS'(1);
        if (started) begin
          if (col_last) begin
            emit_col <= '0;
            emit_row <= emit_row + POS_BITS'(1);
          end else begin
            emit_col <= emit_col + CB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= acc;
  end

  always_ff @(posedge clk) begin
    s1_px   <= px;
    s1_c    <= in_col;
    s1_emit <= started;
    s1_done <= done;
    s1_row  <= emit_row;
    s1_col  <= POS_BITS'(emit_col);
    s1_mask <= {emit_row != '0, !row_last, emit_col != '0, !col_last};
  end

  rgbkf_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata (wr_word),
    .raddr (in_col),
    .rdata (ram_rd)
  );

  // same column written and read in the same cycle (one-pixel rows)
  always_ff @(posedge clk) begin
    if (rst) fwd <= 1'b0;
    else fwd <= s1_valid && (s1_c == in_col);
    fwd_word <= wr_word;
  end

  always_comb begin
    top = fwd ? fwd_word[1] : ram_rd[1];
    mid = fwd ? fwd_word[0] : ram_rd[0];
    wr_word = {mid, s1_px};
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = top;
    win_next[1][2] = mid;
    win_next[2][2] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) win <= '0;
    else if (s1_valid) win <= s1_done ? '0 : win_next;
  end

  always_comb begin
    qw_valid     = s1_valid && s1_emit;
    qw_data.row  = s1_row;
    qw_data.col  = s1_col;
    qw_data.done = s1_done;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if ((r == 0 && !s1_mask[3]) || (r == 2 && !s1_mask[2]) ||
            (k == 0 && !s1_mask[1]) || (k == 2 && !s1_mask[0]))
          qw_data.win[r*3+k] = '0;
        else
          qw_data.win[r*3+k] = win_next[r][k];
      end
    end
  end

endmodule

>>> hw/rtl/rgbkf_queue.sv
// rgbkf_queue: short queue of classified requests between front and back
// depends on rgbkf_pkg
module rgbkf_queue import rgbkf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  win_item_t            wr_data,
  input  logic                 rd,
  output win_item_t            head,
  output logic                 valid,
  output logic [QLVL_BITS-1:0] level
);

  win_item_t            mem [QDEPTH];
  logic [QPTR_BITS-1:0] wp, rp;

  assign head  = mem[rp];
  assign valid = level != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (wr) wp <= wp + QPTR_BITS'(1);
      if (rd) rp <= rp + QPTR_BITS'(1);
      level <= level + QLVL_BITS'(wr) - QLVL_BITS'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

endmodule

>>> hw/rtl/rgbkf_back.sv
// rgbkf_back: three-stage convolution datapath with output register
// depends on rgbkf_pkg
module rgbkf_back import rgbkf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  filter_mode,
  input  logic        q_valid,
  input  win_item_t   q_head,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output out_item_t   pop_data
);

  localparam int PROD_BITS = COEF_BITS + PIX_BITS + 1;
  localparam int ACC_BITS  = PROD_BITS + 4;
  localparam int SOB_BITS  = PIX_BITS + 3;
  localparam int SQ_BITS   = 2 * SOB_BITS;
  localparam int XB        = SQ_BITS + 1;
  localparam int MB        = 3 * PIX_BITS;
  localparam int RB        = 2 * PIX_BITS;
  localparam int SAT_LIM   = PIX_MAX_I * (PIX_MAX_I + 1);
  localparam int RECIP     = PIX_MAX_I + 2;    // 2^P + 1

  function automatic logic signed [SOB_BITS-1:0] sob_h(input pix_t [8:0] w, input int ch);
    logic signed [SOB_BITS-1:0] a, b;
    a = SOB_BITS'(w[6][ch]) + (SOB_BITS'(w[7][ch]) <<< 1) + SOB_BITS'(w[8][ch]);
    b = SOB_BITS'(w[0][ch]) + (SOB_BITS'(w[1][ch]) <<< 1) + SOB_BITS'(w[2][ch]);
    return a - b;
  endfunction

  function automatic logic signed [SOB_BITS-1:0] sob_v(input pix_t [8:0] w, input int ch);
    logic signed [SOB_BITS-1:0] a, b;
    a = SOB_BITS'(w[2][ch]) + (SOB_BITS'(w[5][ch]) <<< 1) + SOB_BITS'(w[8][ch]);
    b = SOB_BITS'(w[0][ch]) + (SOB_BITS'(w[3][ch]) <<< 1) + SOB_BITS'(w[6][ch]);
    return a - b;
  endfunction

  logic v1, v2, v3, adv;
  logic e1, e2;
  logic [POS_BITS-1:0] row1, col1, row2, col2;
  logic done1, done2;

  logic signed [PROD_BITS-1:0] prod1 [3][9];
  logic signed [SOB_BITS-1:0]  h1 [3], vs1 [3];
  logic signed [ACC_BITS-1:0]  acc_c [3], rnd_c [3];
  logic [PIX_BITS-1:0]         conv_c [3], conv2 [3];
  logic [SQ_BITS-1:0]          hh2 [3], vv2 [3];
  logic [XB-1:0]               x_c [3];
  logic [MB-1:0]               m_c [3];
  logic [PIX_BITS-1:0]         q0_c [3], edge_c [3];
  logic [RB-1:0]               r_c [3];

  assign adv   = !v3 || pop;
  assign q_pop = adv && q_valid;
  assign empty = !v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: tap products and sobel sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int t = 0; t < 9; t++)
          prod1[ch][t] <= PROD_BITS'(kernel_coef(filter_mode, 4'(t)) *
                                     $signed({1'b0, q_head.win[t][ch]}));
        h1[ch]  <= sob_h(q_head.win, ch);
        vs1[ch] <= sob_v(q_head.win, ch);
      end
      e1    <= filter_mode == MODE_EDGE;
      row1  <= q_head.row;
      col1  <= q_head.col;
      done1 <= q_head.done;
    end
  end

  // stage 2: accumulate, round and clamp; sobel squares
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_c[ch] = '0;
      for (int t = 0; t < 9; t++) acc_c[ch] = acc_c[ch] + ACC_BITS'(prod1[ch][t]);
      rnd_c[ch] = (acc_c[ch] + ACC_BITS'(1 << (CF_BITS - 1))) >>> CF_BITS;
      if (acc_c[ch] < 0) conv_c[ch] = '0;
      else if (rnd_c[ch] > ACC_BITS'(PIX_MAX_I)) conv_c[ch] = PIX_MAX;
      else conv_c[ch] = rnd_c[ch][PIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        conv2[ch] <= conv_c[ch];
        hh2[ch]   <= SQ_BITS'(h1[ch] * h1[ch]);
        vv2[ch]   <= SQ_BITS'(vs1[ch] * vs1[ch]);
      end
      e2    <= e1;
      row2  <= row1;
      col2  <= col1;
      done2 <= done1;
    end
  end

  // stage 3: squared magnitude over pixel max, rounded, by reciprocal and one correction
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      x_c[ch]  = XB'(hh2[ch]) + XB'(vv2[ch]) + XB'(PIX_MAX_I / 2);
      m_c[ch]  = MB'(x_c[ch][RB-1:0]) * MB'(RECIP);
      q0_c[ch] = m_c[ch][MB-1:RB];
      r_c[ch]  = x_c[ch][RB-1:0] - RB'(q0_c[ch] * RB'(PIX_MAX_I));
      if (x_c[ch] >= XB'(SAT_LIM)) edge_c[ch] = PIX_MAX;
      else if (r_c[ch] >= RB'(PIX_MAX_I)) edge_c[ch] = q0_c[ch] + PIX_BITS'(1);
      else edge_c[ch] = q0_c[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pop_data.red_out    <= e2 ? edge_c[0] : conv2[0];
      pop_data.green_out  <= e2 ? edge_c[1] : conv2[1];
      pop_data.blue_out   <= e2 ? edge_c[2] : conv2[2];
      pop_data.pixel_row  <= row2;
      pop_data.pixel_col  <= col2;
      pop_data.frame_done <= done2;
    end
  end

endmodule

>>> dv/tb.sv
// tb: self-checking testbench for the rgb 3x3 kernel filter core
// depends on rgbkf_pkg and rgb_3x3_kernel_filter_core
`timescale 1ns / 100ps

module tb import rgbkf_pkg::*; ();

  localparam int LINE_LEN   = 2048;
  localparam int SETTLE_CYC = 20;

  // sobel taps, row-major over the 3x3 window
  localparam int SOBEL_H [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
  localparam int SOBEL_V [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  in_item_t    push_data = '0;
  logic        full;
  logic        pop = 1'b0;
  out_item_t   pop_data;
  logic        empty;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_3x3_kernel_filter_core dut (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .empty(empty),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the filter state
  logic [11:0] cur_width, cur_height;
  logic [2:0]  cur_mode;
  logic [7:0]  row_above [LINE_LEN][3];
  logic [7:0]  row_last  [LINE_LEN][3];
  logic [7:0]  window    [3][3][3];
  int          pixels_taken, out_row, out_col, in_col;

  out_item_t   filtered_q [$];
  int          mismatches = 0;
  int          stall_pct = 0;
  int          burst_left = 0;
  int          requests_sent = 0;

  function automatic int coef_for(input logic [2:0] mode, input int tap);
    case (mode)
      MODE_BLUR:    return 28;
      MODE_GAUSS:   return (tap == 4) ? 58 : (tap % 2 == 0) ? 16 : 32;
      MODE_SHARPEN: return (tap == 4) ? 2048 : (tap % 2 == 1) ? -128 : 0;
      MODE_EMBOSS: begin
        case (tap)
          0:       return -256;
          1, 3:    return -128;
          4, 5, 7: return 128;
          8:       return 256;
          default: return 0;
        endcase
      end
      default:      return (tap == 4) ? 256 : 0;
    endcase
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic restart_frame();
    pixels_taken = 0; out_row = 0; out_col = 0; in_col = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        for (int ch = 0; ch < 3; ch++) window[r][k][ch] = '0;
  endtask

  // advance the mirror by one accepted request, queue the filtered pixel if any
  task automatic filter_step(input in_item_t req);
    int w, h, n, c, rr, cc, tap;
    longint acc, sh, sv, res, v;
    logic [7:0] px [3];
    logic [7:0] res8 [3];
    out_item_t o;
    bit done;
    w = clamp_dim(int'(cur_width), LINE_LEN);
    h = clamp_dim(int'(cur_height), MAX_HEIGHT);
    n = pixels_taken;
    c = in_col % LINE_LEN;
    px[0] = req.red_in; px[1] = req.green_in; px[2] = req.blue_in;
    for (int ch = 0; ch < 3; ch++) begin
      if (n >= w * h || req.flush) px[ch] = '0;
      // shift window left, new column = above, last row, this pixel
      for (int r = 0; r < 3; r++) begin
        window[r][0][ch] = window[r][1][ch];
        window[r][1][ch] = window[r][2][ch];
      end
      window[0][2][ch] = row_above[c][ch];
      window[1][2][ch] = row_last[c][ch];
      window[2][2][ch] = px[ch];
      row_above[c][ch] = row_last[c][ch];
      row_last[c][ch] = px[ch];
    end
    in_col = (c + 1 >= w) ? 0 : c + 1;
    pixels_taken = n + 1;
    if (n < w + 1) return;

    done = (out_row + 1 >= h) && (out_col + 1 >= w);
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0; sh = 0; sv = 0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) begin
          rr = out_row + r - 1;
          cc = out_col + k - 1;
          tap = r * 3 + k;
          // taps outside the image read as zero
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            v = window[r][k][ch];
            sh += SOBEL_H[tap] * v;
            sv += SOBEL_V[tap] * v;
            acc += coef_for(cur_mode, tap) * v;
          end
        end
      if (cur_mode == MODE_EDGE) res = (sh * sh + sv * sv + 127) / 255;
      else if (acc < 0) res = 0;
      else res = (acc + 128) >>> 8;
      res8[ch] = (res > 255) ? 8'd255 : res[7:0];
    end
    o.red_out = res8[0]; o.green_out = res8[1]; o.blue_out = res8[2];
    o.pixel_row = out_row[10:0];
    o.pixel_col = out_col[10:0];
    o.frame_done = done;
    filtered_q.insert(filtered_q.size(), o);
    if (done) restart_frame();
    else if (out_col + 1 >= w) begin
      out_col = 0; out_row++;
    end else out_col++;
  endtask

  // send one request, wait for it to be taken, then maybe leave a gap
  task automatic send_pixel(input in_item_t req);
    push <= 1'b1;
    push_data <= req;
    do @(posedge clk); while (full);
    filter_step(req);
    requests_sent++;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else burst_left--;
  endtask

  // every expected pixel out, then let in-flight requests settle
  task automatic drain();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  begin cur_width = val[11:0]; restart_frame(); end
      REG_HEIGHT: begin cur_height = val[11:0]; restart_frame(); end
      REG_MODE:   cur_mode = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int mode);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, mode);
  endtask

  function automatic in_item_t rand_pixel(input int flush_pct);
    in_item_t p;
    p = in_item_t'($bits(in_item_t)'($urandom));
    p.flush = ($urandom_range(0, 99) < flush_pct);
    return p;
  endfunction

  // whole frame then width+1 tail requests; tail may carry junk pixels
  task automatic run_frame(input int w, input int h, input int flush_pct, input int count);
    in_item_t p;
    int total;
    total = clamp_dim(w, LINE_LEN) * clamp_dim(h, MAX_HEIGHT) + clamp_dim(w, LINE_LEN) + 1;
    if (count >= 0 && count < total) total = count;
    for (int i = 0; i < total; i++) begin
      p = rand_pixel(flush_pct);
      if (i >= clamp_dim(w, LINE_LEN) * clamp_dim(h, MAX_HEIGHT) && $urandom_range(0, 1))
        p.flush = 1'b1;
      send_pixel(p);
    end
    push <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && pop && !empty) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", pop_data);
      end else begin
        out_item_t e;
        e = filtered_q.pop_front();
        if (pop_data.red_out !== e.red_out || pop_data.green_out !== e.green_out ||
            pop_data.blue_out !== e.blue_out || pop_data.pixel_row !== e.pixel_row ||
            pop_data.pixel_col !== e.pixel_col || pop_data.frame_done !== e.frame_done) begin
          mismatches++;
          if (mismatches <= 10) $display("pixel mismatch: expected %p got %p", e, pop_data);
        end
      end
    end
  end

  task automatic test_extremes();
    in_item_t p;
    set_frame(3, 2, MODE_IDENTITY);
    for (int i = 0; i < 6; i++) begin
      p = (i % 2) ? in_item_t'({8'hff, 8'hff, 8'hff, 1'b0}) : in_item_t'('0);
      if (i == 4) p.flush = 1'b1;   // flush inside the frame acts as zero pixel
      send_pixel(p);
    end
    for (int i = 0; i < 4; i++) send_pixel(in_item_t'({8'hff, 8'h00, 8'hff, 1'b0}));
    push <= 1'b0;
  endtask

  task automatic test_every_mode();
    for (int m = 0; m < 8; m++) begin   // six and seven are unused codes
      set_frame(2, 2, m);
      run_frame(2, 2, 10, -1);
    end
    set_frame(3, 3, MODE_EDGE);
    stall_pct = 0;
    for (int i = 0; i < 13; i++)
      send_pixel(in_item_t'({8'hff, 8'hff, 8'h00, (i % 4 == 0) ? 1'b1 : 1'b0}));
    push <= 1'b0;
  endtask

  task automatic test_sizes();
    stall_pct = 20;
    set_frame(0, 0, MODE_SHARPEN);       // zero sizes clamp to one
    run_frame(0, 0, 0, -1);
    set_frame(4095, 1, MODE_BLUR);       // width clamps to the line length, partial frame
    run_frame(4095, 1, 5, 60);
    set_frame(1, 4095, MODE_GAUSS);      // height clamps to the maximum, partial frame
    run_frame(1, 4095, 5, 60);
    set_frame(2048, 2048, MODE_EMBOSS);  // exact maximum, partial frame only
    run_frame(2048, 2048, 5, 40);
  endtask

  task automatic test_random();
    int w, h;
    int start;
    start = requests_sent;
    while (requests_sent - start < 160) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
      set_frame(w, h, $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0)
        run_frame(w, h, 20, $urandom_range(1, w * h + w));   // broken frame
      else begin
        run_frame(w, h, 5, -1);
        // sometimes w*h more requests after the frame start a new, unfinished one
        if ($urandom_range(0, 4) == 0) run_frame(w, h, 5, w * h);
      end
    end
  endtask

  initial begin
    cur_width = 12'd640; cur_height = 12'd480; cur_mode = MODE_IDENTITY;
    for (int i = 0; i < LINE_LEN; i++)
      for (int ch = 0; ch < 3; ch++) begin
        row_above[i][ch] = '0; row_last[i][ch] = '0;
      end
    restart_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_every_mode();
    test_sizes();
    test_random();
    drain();
    if (mismatches == 0 && filtered_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
